### src/mpr_pkg.sv
// shared types, constants and helpers for the median prediction restore unit
// no dependencies; used by src/median_prediction_restore_unit.sv
package mpr_pkg;

    localparam int PIX_W      = 8;
    localparam int LWIDTH_W   = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [PIX_W-1:0] SLICE_BIAS = 8'h80;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH = 1'b0,
        CFG_INTERLACED = 1'b1
    } t_cfg_index;

    // line position inside a slice
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_LATER  = 2'd2
    } t_phase;

    typedef logic [PIX_W-1:0] t_pix;

    function automatic t_pix median3(input t_pix a, input t_pix b, input t_pix c);
        t_pix lo;
        t_pix hi;
        t_pix m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

endpackage

### src/mpr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/median_prediction_restore_unit.sv
// median prediction restore: rebuilds an 8-bit plane from residuals in raster order
// depends on src/mpr_pkg.sv and src/mpr_ram.sv
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_residual[7:0], i_slice_first
//  out     | source    | o_out_valid / i_out_stall | o_pixel[7:0]
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data[12:0]
//
// one beat per clock sustained while the output does not stall; each residual beat is
// registered into the reconstruct stage with its line store read, its pixel then into
// the output register; the line store read and left/corner update loop set the figure:
// the reconstruct stage finishes a pixel each unstalled cycle and feeds left straight back
// reset is synchronous, active low; the line store itself is not cleared
// a stall on the output holds the output register and the reconstruct stage,
// and the input then stalls in the same cycle while a beat waits in the reconstruct stage
module median_prediction_restore_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // residual beats
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_residual,
    input  logic                          i_slice_first,
    // pixel beats
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_pixel,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mpr_pkg::LWIDTH_W-1:0]  i_cfg_data
);

    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);          // column count, holds the length too
    localparam int WW    = (CW > mpr_pkg::LWIDTH_W) ? CW : mpr_pkg::LWIDTH_W;

    // configuration
    logic [mpr_pkg::LWIDTH_W-1:0] r_line_width;
    logic                         r_interlaced;

    // stage 0 position state
    logic [CW-1:0]    r_col, n_col;
    mpr_pkg::t_phase  r_phase, n_phase;

    // stage 1 (reconstruct) registers
    logic             r_s1_valid;
    logic [AW-1:0]    r_s1_addr;
    logic             r_s1_col0;
    mpr_pkg::t_phase  r_s1_phase;
    mpr_pkg::t_pix    r_s1_res;
    logic             r_s1_hit;      // read collided with the write of the previous pixel
    mpr_pkg::t_pix    r_s1_fwd;

    // neighbor state
    mpr_pkg::t_pix    r_left;
    mpr_pkg::t_pix    r_corner;

    // output register
    logic             r_out_valid;
    mpr_pkg::t_pix    r_out_pix;

    logic             in_accept;
    logic             s1_fire;
    logic [WW-1:0]    width_ext;
    logic [CW-1:0]    eff_width;
    logic [CW-1:0]    line_len;
    logic [CW-1:0]    cur_col;
    mpr_pkg::t_phase  cur_phase;
    logic [CW-1:0]    col_inc;
    mpr_pkg::t_pix    ram_rdata;
    mpr_pkg::t_pix    above;
    mpr_pkg::t_pix    pred;
    mpr_pkg::t_pix    pix;
    mpr_pkg::t_pix    gradient;

    assign o_cfg_ready = 1'b1;

    // reconstruct stage moves when the output register is free or being drained
    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    // effective logical line length, width saturated to 1..MAX_WIDTH
    assign width_ext = WW'(r_line_width);
    always_comb begin
        if (width_ext == '0) begin
            eff_width = CW'(1);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            eff_width = CW'(MAX_WIDTH);
        end else begin
            eff_width = CW'(width_ext);
        end
        line_len = r_interlaced ? CW'(eff_width << 1) : eff_width;
    end

    // position of the accepted pixel and the position after it
    always_comb begin
        cur_col   = r_col;
        cur_phase = r_phase;
        if (i_slice_first) begin
            cur_col   = '0;
            cur_phase = mpr_pkg::PH_FIRST;
        end else if (r_col >= line_len) begin
            // width shrank mid-line: wrap to a new line
            cur_col   = '0;
            cur_phase = (r_phase == mpr_pkg::PH_FIRST) ? mpr_pkg::PH_SECOND
                                                       : mpr_pkg::PH_LATER;
        end
        col_inc = cur_col + CW'(1);

        n_col   = r_col;
        n_phase = r_phase;
        if (in_accept) begin
            if (col_inc >= line_len) begin
                n_col   = '0;
                n_phase = (cur_phase == mpr_pkg::PH_FIRST) ? mpr_pkg::PH_SECOND
                                                           : mpr_pkg::PH_LATER;
            end else begin
                n_col   = col_inc;
                n_phase = cur_phase;
            end
        end
    end

    // previous line store
    mpr_ram #(
        .WIDTH (mpr_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_addr),
        .i_wdata (pix),
        .i_re    (in_accept),
        .i_raddr (cur_col[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // reconstruct: prediction from left, above and corner, or the slice bias at a slice start
    always_comb begin
        above    = r_s1_hit ? r_s1_fwd : ram_rdata;
        gradient = r_left + above - r_corner;
        if (r_s1_phase == mpr_pkg::PH_FIRST) begin
            pred = r_s1_col0 ? mpr_pkg::SLICE_BIAS : r_left;
        end else if (r_s1_phase == mpr_pkg::PH_SECOND && r_s1_col0) begin
            pred = above;
        end else begin
            pred = mpr_pkg::median3(r_left, above, gradient);
        end
        pix = r_s1_res + pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= mpr_pkg::LWIDTH_W'(1);
            r_interlaced <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mpr_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                mpr_pkg::CFG_INTERLACED: r_interlaced <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_phase     <= mpr_pkg::PH_FIRST;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_corner    <= '0;
        end else begin
            r_col   <= n_col;
            r_phase <= n_phase;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_left      <= pix;
                if (r_s1_phase != mpr_pkg::PH_FIRST) begin
                    r_corner <= above;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr  <= cur_col[AW-1:0];
            r_s1_col0  <= (cur_col == '0);
            r_s1_phase <= cur_phase;
            r_s1_res   <= i_residual;
            // same-edge write to the entry being read: take the written pixel
            r_s1_hit   <= s1_fire && (r_s1_addr == cur_col[AW-1:0]);
            r_s1_fwd   <= pix;
        end
        if (s1_fire) begin
            r_out_pix <= pix;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_out_pix;

endmodule
